### rtl/core/clex_pkg.sv
// Shared types, token codes and keyword tables for the C subset lexer.
package clex_pkg;

    localparam logic [4:0] TK_INT       = 5'd0;
    localparam logic [4:0] TK_RETURN    = 5'd1;
    localparam logic [4:0] TK_VOID      = 5'd2;
    localparam logic [4:0] TK_PLUS      = 5'd3;
    localparam logic [4:0] TK_MINUS     = 5'd4;
    localparam logic [4:0] TK_STAR      = 5'd5;
    localparam logic [4:0] TK_SLASH     = 5'd6;
    localparam logic [4:0] TK_ASSIGN    = 5'd7;
    localparam logic [4:0] TK_EQ        = 5'd8;
    localparam logic [4:0] TK_NE        = 5'd9;
    localparam logic [4:0] TK_LT        = 5'd10;
    localparam logic [4:0] TK_GT        = 5'd11;
    localparam logic [4:0] TK_LE        = 5'd12;
    localparam logic [4:0] TK_GE        = 5'd13;
    localparam logic [4:0] TK_LPAREN    = 5'd14;
    localparam logic [4:0] TK_RPAREN    = 5'd15;
    localparam logic [4:0] TK_LBRACE    = 5'd16;
    localparam logic [4:0] TK_RBRACE    = 5'd17;
    localparam logic [4:0] TK_SEMICOLON = 5'd18;
    localparam logic [4:0] TK_COMMA     = 5'd19;
    localparam logic [4:0] TK_IDENT     = 5'd20;
    localparam logic [4:0] TK_NUMBER    = 5'd21;
    localparam logic [4:0] TK_EOF       = 5'd22;
    localparam logic [4:0] TK_ERROR     = 5'd23;

    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [30:0] number_value;
        logic [7:0]  text_length;
        logic [15:0] line_number;
        logic [15:0] column_number;
        logic        stopped;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step;

    function automatic logic [7:0] kw_len(input logic [1:0] idx);
        logic [7:0] len;
        unique case (idx)
            2'd0:    len = 8'd3;
            2'd1:    len = 8'd6;
            2'd2:    len = 8'd4;
            default: len = 8'd0;
        endcase
        return len;
    endfunction

    // Letters of int, return and void by position.
    function automatic logic [7:0] kw_char(input logic [1:0] idx, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (idx)
            2'd0: begin
                case (pos)
                    3'd0:    ch = 8'h69;
                    3'd1:    ch = 8'h6E;
                    3'd2:    ch = 8'h74;
                    default: ch = 8'h00;
                endcase
            end
            2'd1: begin
                case (pos)
                    3'd0:    ch = 8'h72;
                    3'd1:    ch = 8'h65;
                    3'd2:    ch = 8'h74;
                    3'd3:    ch = 8'h75;
                    3'd4:    ch = 8'h72;
                    3'd5:    ch = 8'h6E;
                    default: ch = 8'h00;
                endcase
            end
            2'd2: begin
                case (pos)
                    3'd0:    ch = 8'h76;
                    3'd1:    ch = 8'h6F;
                    3'd2:    ch = 8'h69;
                    3'd3:    ch = 8'h64;
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### rtl/core/c_subset_lexer_top.sv
// A byte accepted on the input is first registered; the core decodes it combinationally and
// its tokens are written into the result queue, whose head drives the output.
// The input takes one source byte per cycle while it is not stalled; the lexer state updates
// in a single pass per byte. A byte that yields two tokens fills the eight-entry result queue
// faster than it drains, and the input stalls while more than four results are queued.
// Reset is synchronous and active low; it empties the queue and returns the lexer to line 1,
// column 1 with no pending token.
module c_subset_lexer_top #(
    parameter int              TEXT_LIMIT     = 255,
    parameter longint unsigned POSITION_LIMIT = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // source_byte
    input  logic [0:0]  i_s_axis_tuser,   // kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // number_value, text_length, line_number, column_number, zero pad
    output logic [71:0] o_m_axis_tdata,
    output logic [5:0]  o_m_axis_tuser,   // token_kind, stopped
    output logic        o_m_axis_tlast
);

    localparam int QD = 8;
    localparam int QW = $clog2(QD);

    logic                r_in_valid;
    logic                r_in_kind;
    logic [7:0]          r_in_byte;
    clex_pkg::t_step     step;
    clex_pkg::t_result   r_q [QD];
    logic [QW-1:0]       r_wr, r_rd;
    logic [QW:0]         r_count, n_count;
    logic                pop;
    clex_pkg::t_result   head;

    clex_core #(
        .TEXT_LIMIT     (TEXT_LIMIT),
        .POSITION_LIMIT (POSITION_LIMIT)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_in_valid),
        .i_end_kind (r_in_kind),
        .i_byte     (r_in_byte),
        .o_step     (step)
    );

    assign o_s_axis_tready = r_count <= (QW+1)'(QD - 4);
    assign pop             = o_m_axis_tvalid && i_m_axis_tready;
    assign n_count         = r_count + (QW+1)'(step.count) - (QW+1)'(pop);
    assign head            = r_q[r_rd];

    assign o_m_axis_tvalid = r_count != '0;
    assign o_m_axis_tdata  = {1'b0, head.column_number, head.line_number, head.text_length,
                              head.number_value};
    assign o_m_axis_tuser  = {head.stopped, head.token_kind};
    assign o_m_axis_tlast  = head.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_wr       <= '0;
            r_rd       <= '0;
            r_count    <= '0;
        end else begin
            r_in_valid <= i_s_axis_tvalid && o_s_axis_tready;
            r_wr       <= r_wr + QW'(step.count);
            r_rd       <= r_rd + QW'(pop);
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_kind <= i_s_axis_tuser[0];
            r_in_byte <= i_s_axis_tdata;
        end
        if (step.count != 2'd0) begin
            r_q[r_wr] <= step.res0;
        end
        if (step.count == 2'd2) begin
            r_q[r_wr + QW'(1)] <= step.res1;
        end
    end

endmodule

### rtl/core/clex_core.sv
// Lexer state registers and the single-pass token decision for one source item.
module clex_core #(
    parameter int              TEXT_LIMIT     = 255,
    parameter longint unsigned POSITION_LIMIT = 65535
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_end_kind,
    input  logic [7:0]        i_byte,
    output clex_pkg::t_step   o_step
);

    localparam int              POS_W    = $clog2(POSITION_LIMIT + 64'd1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(POSITION_LIMIT);
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);
    localparam logic [7:0]      TEXT_MAX = 8'(TEXT_LIMIT);

    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_IDENT  = 3'd1;
    localparam logic [2:0] M_NUMBER = 3'd2;
    localparam logic [2:0] M_EQ     = 3'd3;
    localparam logic [2:0] M_BANG   = 3'd4;
    localparam logic [2:0] M_LT     = 3'd5;
    localparam logic [2:0] M_GT     = 3'd6;
    localparam logic [2:0] M_HALT   = 3'd7;

    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_BANG   = 8'h21;
    localparam logic [7:0] C_LPAREN = 8'h28;
    localparam logic [7:0] C_RPAREN = 8'h29;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_PLUS   = 8'h2B;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_SEMI   = 8'h3B;
    localparam logic [7:0] C_LT     = 8'h3C;
    localparam logic [7:0] C_EQ     = 8'h3D;
    localparam logic [7:0] C_GT     = 8'h3E;
    localparam logic [7:0] C_UNDER  = 8'h5F;
    localparam logic [7:0] C_LBRACE = 8'h7B;
    localparam logic [7:0] C_RBRACE = 8'h7D;

    logic [2:0]       r_mode, n_mode;
    logic [30:0]      r_acc, n_acc;
    logic [7:0]       r_text, n_text;
    logic [2:0]       r_cand, n_cand;
    logic [POS_W-1:0] r_line, n_line;
    logic [POS_W-1:0] r_col, n_col;

    logic             is_digit, is_alpha, is_start, is_ident, is_space, stop_in;
    logic [POS_W-1:0] adv_line, adv_col;
    logic [15:0]      cur_ln, cur_cl, adv_ln, adv_cl;
    logic [2:0]       cand_hit, fresh_hit;
    logic [7:0]       text_inc;
    logic [34:0]      acc_sum;
    logic [30:0]      acc_next;
    logic [30:0]      digit_val;
    logic             flush_ok;
    clex_pkg::t_result flush_tok;
    logic [4:0]       kw_kind;
    logic [4:0]       single_kind;
    logic             single_ok;
    logic [4:0]       pair_kind;
    logic             lead_ok, tail_ok;
    clex_pkg::t_result lead_tok, tail_tok;
    clex_pkg::t_step  step;

    function automatic clex_pkg::t_result mk(input logic [4:0] k, input logic [30:0] v,
                                             input logic [7:0] l, input logic [15:0] ln,
                                             input logic [15:0] cl, input logic s);
        clex_pkg::t_result r;
        r.token_kind    = k;
        r.number_value  = v;
        r.text_length   = l;
        r.line_number   = ln;
        r.column_number = cl;
        r.stopped       = s;
        r.last          = 1'b0;
        return r;
    endfunction

    always_comb begin
        is_digit  = (i_byte >= 8'h30) && (i_byte <= 8'h39);
        is_alpha  = ((i_byte >= 8'h61) && (i_byte <= 8'h7A)) ||
                    ((i_byte >= 8'h41) && (i_byte <= 8'h5A));
        is_start  = is_alpha || (i_byte == C_UNDER);
        is_ident  = is_start || is_digit;
        is_space  = (i_byte == C_SPACE) || ((i_byte >= 8'h09) && (i_byte <= 8'h0D));
        stop_in   = i_end_kind || (i_byte == C_NUL);
        digit_val = {27'd0, i_byte[3:0]};

        if (i_byte == C_LF) begin
            adv_line = (r_line < POS_MAX) ? r_line + POS_ONE : r_line;
            adv_col  = POS_ONE;
        end else begin
            adv_line = r_line;
            adv_col  = (r_col < POS_MAX) ? r_col + POS_ONE : r_col;
        end
        cur_ln = 16'(r_line);
        cur_cl = 16'(r_col);
        adv_ln = 16'(adv_line);
        adv_cl = 16'(adv_col);

        for (int i = 0; i < 3; i++) begin
            cand_hit[i]  = (r_text < clex_pkg::kw_len(2'(i))) &&
                           (clex_pkg::kw_char(2'(i), r_text[2:0]) == i_byte);
            fresh_hit[i] = clex_pkg::kw_char(2'(i), 3'd0) == i_byte;
        end

        text_inc = (r_text < TEXT_MAX) ? r_text + 8'd1 : r_text;
        acc_sum  = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {4'd0, digit_val};
        acc_next = (acc_sum > {4'd0, clex_pkg::NUM_MAX}) ? clex_pkg::NUM_MAX : acc_sum[30:0];

        kw_kind = clex_pkg::TK_IDENT;
        for (int i = 0; i < 3; i++) begin
            if (r_cand[i] && (r_text == clex_pkg::kw_len(2'(i)))) begin
                kw_kind = 5'(i);
            end
        end

        flush_ok  = 1'b1;
        flush_tok = mk(clex_pkg::TK_ASSIGN, 31'd0, 8'd1, cur_ln, cur_cl, 1'b0);
        unique case (r_mode)
            M_IDENT:  flush_tok = mk(kw_kind, 31'd0, r_text, cur_ln, cur_cl, 1'b0);
            M_NUMBER: flush_tok = mk(clex_pkg::TK_NUMBER, r_acc, r_text, cur_ln, cur_cl, 1'b0);
            M_EQ:     flush_tok = mk(clex_pkg::TK_ASSIGN, 31'd0, 8'd1, cur_ln, cur_cl, 1'b0);
            M_BANG:   flush_tok = mk(clex_pkg::TK_ERROR, 31'd0, 8'd1, cur_ln, cur_cl, 1'b0);
            M_LT:     flush_tok = mk(clex_pkg::TK_LT, 31'd0, 8'd1, cur_ln, cur_cl, 1'b0);
            M_GT:     flush_tok = mk(clex_pkg::TK_GT, 31'd0, 8'd1, cur_ln, cur_cl, 1'b0);
            default:  flush_ok  = 1'b0;
        endcase

        single_ok   = 1'b1;
        single_kind = clex_pkg::TK_PLUS;
        unique case (i_byte)
            C_PLUS:   single_kind = clex_pkg::TK_PLUS;
            C_MINUS:  single_kind = clex_pkg::TK_MINUS;
            C_STAR:   single_kind = clex_pkg::TK_STAR;
            C_SLASH:  single_kind = clex_pkg::TK_SLASH;
            C_LPAREN: single_kind = clex_pkg::TK_LPAREN;
            C_RPAREN: single_kind = clex_pkg::TK_RPAREN;
            C_LBRACE: single_kind = clex_pkg::TK_LBRACE;
            C_RBRACE: single_kind = clex_pkg::TK_RBRACE;
            C_SEMI:   single_kind = clex_pkg::TK_SEMICOLON;
            C_COMMA:  single_kind = clex_pkg::TK_COMMA;
            default:  single_ok   = 1'b0;
        endcase

        unique case (r_mode)
            M_BANG:  pair_kind = clex_pkg::TK_NE;
            M_LT:    pair_kind = clex_pkg::TK_LE;
            M_GT:    pair_kind = clex_pkg::TK_GE;
            default: pair_kind = clex_pkg::TK_EQ;
        endcase

        n_mode   = r_mode;
        n_acc    = r_acc;
        n_text   = r_text;
        n_cand   = r_cand;
        n_line   = r_line;
        n_col    = r_col;
        lead_ok  = 1'b0;
        tail_ok  = 1'b0;
        lead_tok = flush_tok;
        tail_tok = mk(clex_pkg::TK_EOF, 31'd0, 8'd0, cur_ln, cur_cl, 1'b0);

        if (i_valid) begin
            if (stop_in) begin
                if (r_mode != M_HALT) begin
                    lead_ok = flush_ok;
                    tail_ok = 1'b1;
                    n_mode  = M_HALT;
                end
                if (i_end_kind) begin
                    n_mode = M_IDLE;
                    n_acc  = 31'd0;
                    n_text = 8'd0;
                    n_cand = 3'b111;
                    n_line = POS_ONE;
                    n_col  = POS_ONE;
                end
            end else if (r_mode == M_HALT) begin
                n_mode = M_HALT;
            end else if ((r_mode == M_IDENT) && is_ident) begin
                n_line = adv_line;
                n_col  = adv_col;
                n_cand = r_cand & cand_hit;
                n_text = text_inc;
            end else if ((r_mode == M_NUMBER) && is_digit) begin
                n_line = adv_line;
                n_col  = adv_col;
                n_acc  = acc_next;
                n_text = text_inc;
            end else if ((i_byte == C_EQ) && (r_mode >= M_EQ) && (r_mode <= M_GT)) begin
                n_line   = adv_line;
                n_col    = adv_col;
                tail_ok  = 1'b1;
                tail_tok = mk(pair_kind, 31'd0, 8'd2, adv_ln, adv_cl, 1'b0);
                n_mode   = M_IDLE;
            end else begin
                lead_ok = flush_ok;
                n_line  = adv_line;
                n_col   = adv_col;
                n_mode  = M_IDLE;
                if (is_space) begin
                    n_mode = M_IDLE;
                end else if (is_digit) begin
                    n_mode = M_NUMBER;
                    n_acc  = digit_val;
                    n_text = 8'd1;
                end else if (is_start) begin
                    n_mode = M_IDENT;
                    n_text = 8'd1;
                    n_cand = fresh_hit;
                end else if (i_byte == C_EQ) begin
                    n_mode = M_EQ;
                end else if (i_byte == C_BANG) begin
                    n_mode = M_BANG;
                end else if (i_byte == C_LT) begin
                    n_mode = M_LT;
                end else if (i_byte == C_GT) begin
                    n_mode = M_GT;
                end else if (single_ok) begin
                    tail_ok  = 1'b1;
                    tail_tok = mk(single_kind, 31'd0, 8'd1, adv_ln, adv_cl, 1'b0);
                end else begin
                    tail_ok  = 1'b1;
                    tail_tok = mk(clex_pkg::TK_ERROR, 31'd0, 8'd1, adv_ln, adv_cl, 1'b1);
                    n_mode   = M_HALT;
                end
            end
        end

        step.count = 2'd0;
        step.res0  = lead_tok;
        step.res1  = tail_tok;
        if (lead_ok && tail_ok) begin
            step.count     = 2'd2;
            step.res1.last = 1'b1;
        end else if (lead_ok) begin
            step.count     = 2'd1;
            step.res0.last = 1'b1;
        end else if (tail_ok) begin
            step.count     = 2'd1;
            step.res0      = tail_tok;
            step.res0.last = 1'b1;
        end
    end

    assign o_step = step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_acc  <= 31'd0;
            r_text <= 8'd0;
            r_cand <= 3'b111;
            r_line <= POS_ONE;
            r_col  <= POS_ONE;
        end else begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_text <= n_text;
            r_cand <= n_cand;
            r_line <= n_line;
            r_col  <= n_col;
        end
    end

endmodule

### rtl/core/clex_chk.sv
// Port-level checker for the C subset lexer, bound to the top level.
module clex_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [71:0] o_m_axis_tdata,
    input logic [5:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) &&
            $stable(o_m_axis_tlast))
        else $error("result item changed while stalled");

    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[5] |->
            o_m_axis_tuser[4:0] == clex_pkg::TK_ERROR && o_m_axis_tlast)
        else $error("stopping flag on a token that is not a final error");

    a_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[4:0] == clex_pkg::TK_EOF |->
            o_m_axis_tlast && o_m_axis_tdata[38:0] == 39'd0)
        else $error("end token not final or carries text");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[4:0] != clex_pkg::TK_EOF |->
            o_m_axis_tdata[38:31] != 8'd0 && o_m_axis_tdata[54:39] != 16'd0)
        else $error("token without length or line");

    a_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[30:0] != 31'd0 |->
            o_m_axis_tuser[4:0] == clex_pkg::TK_NUMBER)
        else $error("value on a token that is not a number");

endmodule

bind c_subset_lexer_top clex_chk u_clex_chk (.*);

### sim/c_subset_lexer_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench that streams C source bytes into the lexer and checks every token.
module c_subset_lexer_top_tb;

    localparam int              LEX_TEXT_LIMIT = 255;
    localparam longint unsigned LEX_POS_LIMIT  = 65535;
    localparam longint unsigned LEX_NUM_LIMIT  = 64'd2147483647;

    typedef enum logic [2:0] {
        LX_IDLE, LX_WORD, LX_NUM, LX_EQ, LX_BANG, LX_LT, LX_GT, LX_HALT
    } t_lex_state;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        src_valid = 1'b0;
    logic        src_ready;
    logic [7:0]  src_data  = 8'h00;
    logic [0:0]  src_user  = 1'b0;
    logic        tok_valid;
    logic        tok_ready = 1'b0;
    // number_value, text_length, line_number, column_number, zero pad
    logic [71:0] tok_data;
    logic [5:0]  tok_user;   // token_kind, stopped
    logic        tok_last;

    clex_pkg::t_result token_q[$];
    int          mismatches = 0;
    int          live_items = 0;
    int          step_count;
    bit          no_idle    = 1'b0;
    int unsigned sink_wait  = 0;

    t_lex_state      lx_mode  = LX_IDLE;
    longint unsigned lx_value = 0;
    int              lx_len   = 0;
    logic [2:0]      lx_kw    = 3'b111;
    longint unsigned lx_line  = 1;
    longint unsigned lx_col   = 1;

    c_subset_lexer_top #(
        .TEXT_LIMIT     (LEX_TEXT_LIMIT),
        .POSITION_LIMIT (LEX_POS_LIMIT)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (src_valid),
        .o_s_axis_tready (src_ready),
        .i_s_axis_tdata  (src_data),
        .i_s_axis_tuser  (src_user),
        .o_m_axis_tvalid (tok_valid),
        .i_m_axis_tready (tok_ready),
        .o_m_axis_tdata  (tok_data),
        .o_m_axis_tuser  (tok_user),
        .o_m_axis_tlast  (tok_last)
    );

    always #2 clk = ~clk;

    initial begin
        #5_000_000;
        $display("c_subset_lexer_top test failed");
        $finish;
    end

    function automatic int unsigned draw_wait();
        if (no_idle) begin
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic bit is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_word_start(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic int kw_length(int idx);
        case (idx)
            0:       return 3;
            1:       return 6;
            default: return 4;
        endcase
    endfunction

    function automatic logic [7:0] kw_letter(int idx, int pos);
        string w;
        case (idx)
            0:       w = "int";
            1:       w = "return";
            default: w = "void";
        endcase
        if (pos >= w.len()) begin
            return 8'h00;
        end
        return w[pos];
    endfunction

    task automatic reset_lexer();
        lx_mode  = LX_IDLE;
        lx_value = 0;
        lx_len   = 0;
        lx_kw    = 3'b111;
        lx_line  = 1;
        lx_col   = 1;
    endtask

    task automatic note_token(logic [4:0] k, longint unsigned v, int len, bit stop);
        clex_pkg::t_result r;
        r.token_kind    = k;
        r.number_value  = v[30:0];
        r.text_length   = len[7:0];
        r.line_number   = lx_line[15:0];
        r.column_number = lx_col[15:0];
        r.stopped       = stop;
        r.last          = 1'b0;
        token_q.push_back(r);
        step_count++;
    endtask

    task automatic move_position(logic [7:0] c);
        if (c == 8'h0A) begin
            if (lx_line < LEX_POS_LIMIT) begin
                lx_line++;
            end
            lx_col = 1;
        end else if (lx_col < LEX_POS_LIMIT) begin
            lx_col++;
        end
    endtask

    task automatic count_text();
        if (lx_len < LEX_TEXT_LIMIT) begin
            lx_len++;
        end
    endtask

    task automatic take_word_char(logic [7:0] c);
        for (int i = 0; i < 3; i++) begin
            if (lx_len >= kw_length(i) || kw_letter(i, lx_len) != c) begin
                lx_kw[i] = 1'b0;
            end
        end
        count_text();
    endtask

    task automatic flush_held();
        logic [4:0] k;
        k = clex_pkg::TK_IDENT;
        case (lx_mode)
            LX_WORD: begin
                for (int i = 0; i < 3; i++) begin
                    if (lx_kw[i] && lx_len == kw_length(i)) begin
                        k = (i == 0) ? clex_pkg::TK_INT :
                            (i == 1) ? clex_pkg::TK_RETURN : clex_pkg::TK_VOID;
                    end
                end
                note_token(k, 0, lx_len, 1'b0);
            end
            LX_NUM:  note_token(clex_pkg::TK_NUMBER, lx_value, lx_len, 1'b0);
            LX_EQ:   note_token(clex_pkg::TK_ASSIGN, 0, 1, 1'b0);
            LX_BANG: note_token(clex_pkg::TK_ERROR, 0, 1, 1'b0);
            LX_LT:   note_token(clex_pkg::TK_LT, 0, 1, 1'b0);
            LX_GT:   note_token(clex_pkg::TK_GT, 0, 1, 1'b0);
            default: ;
        endcase
        if (lx_mode != LX_HALT) begin
            lx_mode = LX_IDLE;
        end
    endtask

    task automatic begin_token(logic [7:0] c);
        logic [4:0] k;
        bit         known;
        known = 1'b1;
        k     = clex_pkg::TK_ERROR;
        move_position(c);
        if (is_blank(c)) begin
            return;
        end
        if (is_dig(c)) begin
            lx_mode  = LX_NUM;
            lx_value = 64'(c - 8'h30);
            lx_len   = 1;
            return;
        end
        if (is_word_start(c)) begin
            lx_mode = LX_WORD;
            lx_len  = 0;
            lx_kw   = 3'b111;
            take_word_char(c);
            return;
        end
        case (c)
            "+":     k = clex_pkg::TK_PLUS;
            "-":     k = clex_pkg::TK_MINUS;
            "*":     k = clex_pkg::TK_STAR;
            "/":     k = clex_pkg::TK_SLASH;
            "(":     k = clex_pkg::TK_LPAREN;
            ")":     k = clex_pkg::TK_RPAREN;
            "{":     k = clex_pkg::TK_LBRACE;
            "}":     k = clex_pkg::TK_RBRACE;
            ";":     k = clex_pkg::TK_SEMICOLON;
            ",":     k = clex_pkg::TK_COMMA;
            "=":     lx_mode = LX_EQ;
            "!":     lx_mode = LX_BANG;
            "<":     lx_mode = LX_LT;
            ">":     lx_mode = LX_GT;
            default: known = 1'b0;
        endcase
        if (c == "=" || c == "!" || c == "<" || c == ">") begin
            return;
        end
        if (known) begin
            note_token(k, 0, 1, 1'b0);
        end else begin
            note_token(clex_pkg::TK_ERROR, 0, 1, 1'b1);
            lx_mode = LX_HALT;
        end
    endtask

    task automatic lex_byte(logic kind, logic [7:0] c);
        longint unsigned v;
        logic [4:0]      k;
        step_count = 0;
        if (kind || lx_mode != LX_HALT) begin
            live_items++;
        end
        if (kind || c == 8'h00) begin
            if (lx_mode != LX_HALT) begin
                flush_held();
                note_token(clex_pkg::TK_EOF, 0, 0, 1'b0);
                lx_mode = LX_HALT;
            end
            if (kind) begin
                reset_lexer();
            end
        end else if (lx_mode == LX_HALT) begin
        end else if (lx_mode == LX_WORD && (is_word_start(c) || is_dig(c))) begin
            move_position(c);
            take_word_char(c);
        end else if (lx_mode == LX_NUM && is_dig(c)) begin
            v = lx_value * 64'd10 + 64'(c - 8'h30);
            lx_value = (v > LEX_NUM_LIMIT) ? LEX_NUM_LIMIT : v;
            move_position(c);
            count_text();
        end else if (c == "=" && lx_mode inside {LX_EQ, LX_BANG, LX_LT, LX_GT}) begin
            case (lx_mode)
                LX_EQ:   k = clex_pkg::TK_EQ;
                LX_BANG: k = clex_pkg::TK_NE;
                LX_LT:   k = clex_pkg::TK_LE;
                default: k = clex_pkg::TK_GE;
            endcase
            move_position(c);
            note_token(k, 0, 2, 1'b0);
            lx_mode = LX_IDLE;
        end else begin
            flush_held();
            begin_token(c);
        end
        if (step_count > 0) begin
            token_q[token_q.size() - 1].last = 1'b1;
        end
    endtask

    task automatic send_item(logic kind, logic [7:0] c);
        int unsigned gap;
        gap = draw_wait();
        if (gap > 0) begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= c;
        src_user  <= kind;
        do @(posedge clk); while (!src_ready);
        lex_byte(kind, c);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(1'b0, s[i]);
        end
    endtask

    task automatic send_end();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        send_item(1'b1, b);
    endtask

    task automatic drain();
        src_valid <= 1'b0;
        while (token_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [7:0] word_char(bit digits_ok);
        int unsigned r;
        r = $urandom_range(0, digits_ok ? 62 : 52);
        if (r < 26) begin
            return 8'("a" + r);
        end else if (r < 52) begin
            return 8'("A" + r - 26);
        end else if (r == 52) begin
            return "_";
        end
        return 8'("0" + r - 53);
    endfunction

    task automatic send_word(int n);
        send_item(1'b0, word_char(1'b0));
        for (int i = 1; i < n; i++) begin
            send_item(1'b0, word_char(1'b1));
        end
    endtask

    task automatic send_digits(int n);
        logic [7:0] d;
        for (int i = 0; i < n; i++) begin
            d = 8'("0" + $urandom_range(0, 9));
            send_item(1'b0, d);
        end
    endtask

    task automatic send_blank();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0:       b = 8'h09;
            1:       b = 8'h0A;
            2:       b = 8'h0B;
            3:       b = 8'h0C;
            4:       b = 8'h0D;
            default: b = " ";
        endcase
        send_item(1'b0, b);
    endtask

    task automatic send_keyword_like();
        case ($urandom_range(0, 10))
            0, 1:    send_text("int");
            2, 3:    send_text("return");
            4, 5:    send_text("void");
            6:       send_text("in");
            7:       send_text("retur");
            8:       send_text("voids");
            9:       send_text("int_");
            default: send_text("Int");
        endcase
    endtask

    task automatic send_operator();
        string singles;
        singles = "+-*/(){};,=<>!";
        case ($urandom_range(0, 5))
            0:       send_text("==");
            1:       send_text("!=");
            2:       send_text("<=");
            3:       send_text(">=");
            default: send_item(1'b0, singles[$urandom_range(0, singles.len() - 1)]);
        endcase
    endtask

    task automatic send_program();
        int unsigned pieces;
        int unsigned pick;
        logic [7:0]  noise;
        pieces  = $urandom_range(3, 25);
        no_idle = ($urandom_range(0, 4) == 0);
        repeat (pieces) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                send_keyword_like();
            end else if (pick < 35) begin
                send_word(($urandom_range(0, 19) == 0) ? $urandom_range(13, 40)
                                                         : $urandom_range(1, 8));
            end else if (pick < 50) begin
                send_digits(($urandom_range(0, 9) == 0) ? $urandom_range(10, 14)
                                                          : $urandom_range(1, 5));
            end else if (pick < 80) begin
                send_operator();
            end else begin
                send_blank();
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_blank();
            end else if (pick < 43) begin
                noise = 8'($urandom_range(1, 255));
                send_item(1'b0, noise);
            end else if (pick < 44) begin
                send_item(1'b0, 8'h00);
            end
        end
        send_end();
        no_idle = 1'b0;
    endtask

    task automatic check_token(clex_pkg::t_result got);
        clex_pkg::t_result want;
        if (token_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected token: kind %0d value %0d len %0d line %0d col %0d",
                         got.token_kind, got.number_value, got.text_length,
                         got.line_number, got.column_number);
            end
            return;
        end
        want = token_q.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("expected kind %0d val %0d len %0d ln %0d col %0d stop %0b last %0b",
                         want.token_kind, want.number_value, want.text_length,
                         want.line_number, want.column_number, want.stopped, want.last);
                $display("actual   kind %0d val %0d len %0d ln %0d col %0d stop %0b last %0b",
                         got.token_kind, got.number_value, got.text_length,
                         got.line_number, got.column_number, got.stopped, got.last);
            end
        end
    endtask

    always @(posedge clk) begin : token_sink
        clex_pkg::t_result got;
        int unsigned       w;
        if (!rst_n) begin
            tok_ready <= 1'b0;
            sink_wait <= 0;
        end else if (tok_valid && tok_ready) begin
            got.token_kind    = tok_user[4:0];
            got.stopped       = tok_user[5];
            got.number_value  = tok_data[30:0];
            got.text_length   = tok_data[38:31];
            got.line_number   = tok_data[54:39];
            got.column_number = tok_data[70:55];
            got.last          = tok_last;
            check_token(got);
            w = draw_wait();
            if (w == 0) begin
                tok_ready <= 1'b1;
            end else begin
                tok_ready <= 1'b0;
                sink_wait <= w;
            end
        end else if (sink_wait > 1) begin
            sink_wait <= sink_wait - 1;
        end else begin
            sink_wait <= 0;
            tok_ready <= 1'b1;
        end
    end

    task automatic test_operators();
        send_text("+-*/(){};,=== !=<=>=<>!x");
        send_end();
        drain();
    endtask

    task automatic test_special_cases();
        send_text("int return void");
        send_item(1'b0, 8'h0A);
        send_text("9a");
        send_item(1'b0, 8'h09);
        send_item(1'b0, 8'h0B);
        send_item(1'b0, 8'h0C);
        send_item(1'b0, 8'h0D);
        send_text("0");
        send_item(1'b0, 8'hFF);
        send_text("q");
        send_end();
        send_text("ab");
        send_item(1'b0, 8'h00);
        send_text("c");
        send_end();
        send_text("x");
        send_end();
        send_item(1'b0, 8'h01);
        send_end();
        drain();
    endtask

    task automatic test_long_tokens();
        send_text("return");
        for (int i = 0; i < 294; i++) begin
            send_item(1'b0, word_char(1'b1));
        end
        send_item(1'b0, " ");
        send_item(1'b0, 8'("1" + $urandom_range(0, 8)));
        send_digits(19);
        send_text(";2147483647 2147483648 intx");
        send_end();
        drain();
    endtask

    task automatic test_random_programs();
        live_items = 0;
        while (live_items < 200) begin
            send_program();
        end
        drain();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_operators();
        test_special_cases();
        test_long_tokens();
        test_random_programs();
        if (mismatches == 0 && token_q.size() == 0) begin
            $display("c_subset_lexer_top test passed");
        end else begin
            $display("c_subset_lexer_top test failed");
        end
        $finish;
    end

endmodule
